// File: rtl/pal_pkg.sv
// shared types and constants for the pending alarm list
package pal_pkg;

  localparam int ENTRIES = 8;
  localparam int CODE_W  = 16;
  localparam int GRP_LSB = 8;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int OUT_CNT_W = 4;

  // operation codes of an input word
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_DEL  = 3'd1,
    OP_DGRP = 3'd2,
    OP_GET  = 3'd3,
    OP_CLR  = 3'd4,
    OP_POLL = 3'd5
  } op_t;

  // sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } st_t;

  // broadcast lookup command, read by every cell
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              grp_mode;
    logic              get_en;
  } cmd_t;

  // broadcast update actions, decided from the end of the chain
  typedef struct packed {
    logic remove_en;
    logic clr_marks;
    logic add_en;
    logic clear_all;
  } act_t;

  // ripple link handed from each cell to the next one
  typedef struct packed {
    logic              hit;
    logic              rm_ann;
    logic              taken;
    logic [CODE_W-1:0] gcode;
    logic              prev_valid;
  } link_t;

  // contents of one cell, handed to the left neighbor on removal
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              ann;
    logic              valid;
  } ent_t;

  // entry count masked to the result field width
  function automatic logic [OUT_CNT_W-1:0] mask_count(input logic [CNT_W-1:0] cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    return wide[OUT_CNT_W-1:0];
  endfunction

endpackage

// File: rtl/pal_cell.sv
// one list entry cell: code, announced mark and valid bit with neighbor links
module pal_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  pal_pkg::cmd_t  cmd,
  input  pal_pkg::act_t  act,
  input  pal_pkg::link_t lnk_i,
  output pal_pkg::link_t lnk_o,
  input  pal_pkg::ent_t  right_i,
  output pal_pkg::ent_t  ent_o
);

  logic [pal_pkg::CODE_W-1:0] code_r, code_nxt;
  logic ann_r, ann_nxt;
  logic vld_r, vld_nxt;
  logic match_exact, match_grp, match, shift, avail;

  // match against the command code, full or by group byte
  always_comb begin
    match_exact = vld_r && (code_r == cmd.code);
    match_grp   = vld_r && (code_r[pal_pkg::CODE_W-1:pal_pkg::GRP_LSB] ==
                            cmd.code[pal_pkg::CODE_W-1:pal_pkg::GRP_LSB]);
    match       = cmd.grp_mode ? match_grp : match_exact;
    shift       = act.remove_en && (lnk_i.hit || match);
    avail       = vld_r && !ann_r && !lnk_i.taken;
  end

  // link toward the next cell
  always_comb begin
    lnk_o.hit        = lnk_i.hit || match;
    lnk_o.rm_ann     = lnk_i.hit ? lnk_i.rm_ann : (match && ann_r);
    lnk_o.taken      = lnk_i.taken || (vld_r && !ann_r);
    lnk_o.gcode      = avail ? code_r : lnk_i.gcode;
    lnk_o.prev_valid = vld_r;
  end

  assign ent_o = '{code: code_r, ann: ann_r, valid: vld_r};

  // next cell contents
  always_comb begin
    code_nxt = code_r;
    ann_nxt  = ann_r;
    vld_nxt  = vld_r;
    if (act.clear_all) begin
      vld_nxt = 1'b0;
      ann_nxt = 1'b0;
    end else if (shift) begin
      code_nxt = right_i.code;
      ann_nxt  = right_i.ann;
      vld_nxt  = right_i.valid;
    end else if (act.add_en && !vld_r && lnk_i.prev_valid) begin
      code_nxt = cmd.code;
      ann_nxt  = 1'b0;
      vld_nxt  = 1'b1;
    end else if (cmd.get_en && avail) begin
      ann_nxt = 1'b1;
    end
    if (act.clr_marks) begin
      ann_nxt = 1'b0;
    end
  end

  // control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ann_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      ann_r <= ann_nxt;
      vld_r <= vld_nxt;
    end
  end

  // stored code
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

endmodule

// File: rtl/pending_alarm_list.sv
// pending alarm list top level: command sequencer, entry count and cell row
//
// Usage: a command word (in_operation, in_alarm_code_in) is taken at a
// rising edge where start is high and busy is low. The block holds an
// ordered, compacted list of alarm codes in a row of cells; each cell
// compares its own entry and, on a removal, takes its right neighbor's
// entry so the list stays packed.
// Every command returns exactly one result word, shown for one cycle
// with out_valid high; the receiver cannot stall it.
// Busy is high in the execute state entered at the accepting edge, and the
// result is registered and shown in the cycle after the last execute cycle;
// the next command can be taken while the result is shown. Group delete
// removes one matching entry per execute cycle until nothing matches.
// The per-cycle work is set by the ripple chain through the cell row.
// Reset (rst_n low, synchronous) empties the list, clears every announced
// mark and the emptied flag, and drops busy and out_valid.
module pending_alarm_list (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [2:0]                           in_operation,
  input  logic [pal_pkg::CODE_W-1:0]           in_alarm_code_in,
  output logic                                 out_valid,
  output logic [pal_pkg::CODE_W-1:0]           out_alarm_code_out,
  output logic                                 out_alarm_found,
  output logic                                 out_list_emptied,
  output logic [pal_pkg::OUT_CNT_W-1:0]        out_entry_count
);

  pal_pkg::st_t state_r, state_nxt;
  logic [2:0] op_r;
  logic [pal_pkg::CODE_W-1:0] code_r;
  logic [pal_pkg::CNT_W-1:0] count_r, count_nxt;
  logic flag_r, flag_nxt;
  logic done;

  logic out_valid_r;
  logic [pal_pkg::CODE_W-1:0] res_code_r, res_code_nxt;
  logic res_found_r, res_found_nxt;
  logic res_empt_r, res_empt_nxt;
  logic [pal_pkg::OUT_CNT_W-1:0] res_cnt_r;

  pal_pkg::cmd_t cmd;
  pal_pkg::act_t act;
  pal_pkg::link_t lnk [pal_pkg::ENTRIES+1];
  pal_pkg::ent_t  ent [pal_pkg::ENTRIES+1];
  logic [pal_pkg::ENTRIES-1:0] vld_vec;
  logic full, any_hit;

  // row of cells
  assign lnk[0] = '{hit: 1'b0, rm_ann: 1'b0, taken: 1'b0, gcode: '0, prev_valid: 1'b1};
  assign ent[pal_pkg::ENTRIES] = '{code: '0, ann: 1'b0, valid: 1'b0};

  for (genvar i = 0; i < pal_pkg::ENTRIES; i++) begin : g_cell
    pal_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .act     (act),
      .lnk_i   (lnk[i]),
      .lnk_o   (lnk[i+1]),
      .right_i (ent[i+1]),
      .ent_o   (ent[i])
    );
    assign vld_vec[i] = ent[i].valid;
  end

  assign full    = (count_r == pal_pkg::CNT_W'(pal_pkg::ENTRIES));
  assign any_hit = lnk[pal_pkg::ENTRIES].hit;
  assign busy    = (state_r == pal_pkg::ST_EXEC);

  // lookup command to the cells
  always_comb begin
    cmd.code     = code_r;
    cmd.grp_mode = (op_r == pal_pkg::OP_DGRP);
    cmd.get_en   = busy && (op_r == pal_pkg::OP_GET);
  end

  // actions, counts and result of the execute cycle
  always_comb begin
    act          = '0;
    count_nxt    = count_r;
    flag_nxt     = flag_r;
    done         = 1'b0;
    res_code_nxt = '0;
    res_found_nxt = 1'b0;
    res_empt_nxt = 1'b0;
    if (busy) begin
      done = 1'b1;
      case (pal_pkg::op_t'(op_r))
        pal_pkg::OP_ADD: begin
          if (!full) begin
            flag_nxt = 1'b0;
            if (!any_hit) begin
              act.add_en = 1'b1;
              count_nxt  = count_r + pal_pkg::CNT_W'(1);
            end
          end
        end
        pal_pkg::OP_DEL, pal_pkg::OP_DGRP: begin
          if (any_hit) begin
            act.remove_en = 1'b1;
            act.clr_marks = lnk[pal_pkg::ENTRIES].rm_ann;
            count_nxt     = count_r - pal_pkg::CNT_W'(1);
            if (count_r == pal_pkg::CNT_W'(1)) begin
              flag_nxt = 1'b1;
            end
            // group delete keeps going until nothing matches
            if (op_r == pal_pkg::OP_DGRP) begin
              done = 1'b0;
            end
          end
        end
        pal_pkg::OP_GET: begin
          res_found_nxt = lnk[pal_pkg::ENTRIES].taken;
          res_code_nxt  = lnk[pal_pkg::ENTRIES].taken ? lnk[pal_pkg::ENTRIES].gcode : '0;
        end
        pal_pkg::OP_CLR: begin
          act.clear_all = 1'b1;
          count_nxt     = '0;
        end
        pal_pkg::OP_POLL: begin
          res_empt_nxt = flag_r;
          flag_nxt     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pal_pkg::ST_IDLE: begin
        if (start) state_nxt = pal_pkg::ST_EXEC;
      end
      pal_pkg::ST_EXEC: begin
        if (done) state_nxt = pal_pkg::ST_IDLE;
      end
      default: state_nxt = pal_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pal_pkg::ST_IDLE;
      count_r     <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= done;
    end
  end

  // captured command word and result word
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r   <= in_operation;
      code_r <= in_alarm_code_in;
    end
    if (done) begin
      res_code_r  <= res_code_nxt;
      res_found_r <= res_found_nxt;
      res_empt_r  <= res_empt_nxt;
      res_cnt_r   <= pal_pkg::mask_count(count_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_alarm_code_out = res_code_r;
  assign out_alarm_found    = res_found_r;
  assign out_list_emptied   = res_empt_r;
  assign out_entry_count    = res_cnt_r;

  // the count follows the number of valid cells
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(count_r))
    else $error("entry count differs from occupied cells");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= pal_pkg::CNT_W'(pal_pkg::ENTRIES))
    else $error("entry count above capacity");

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == pal_pkg::ST_EXEC))
    else $error("result strobe without an execute cycle");

  a_found_from_get: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alarm_found) |-> $past(op_r == pal_pkg::OP_GET))
    else $error("alarm found on a command other than get next");

  a_emptied_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_list_emptied) |-> $past(op_r == pal_pkg::OP_POLL))
    else $error("emptied report on a command other than poll");

endmodule

// File: tb/pending_alarm_list_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the pending alarm list: directed and random command words
module pending_alarm_list_tb;

  // command values outside the defined operation set
  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  localparam int RANDOM_WORDS = 1950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [2:0]                 op;
    logic [pal_pkg::CODE_W-1:0] code;
  } cmd_word_t;

  typedef struct packed {
    logic [pal_pkg::CODE_W-1:0]    code;
    logic                          found;
    logic                          emptied;
    logic [pal_pkg::OUT_CNT_W-1:0] cnt;
  } result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [2:0]                    in_operation;
  logic [pal_pkg::CODE_W-1:0]    in_alarm_code_in;
  logic                          out_valid;
  logic [pal_pkg::CODE_W-1:0]    out_alarm_code_out;
  logic                          out_alarm_found;
  logic                          out_list_emptied;
  logic [pal_pkg::OUT_CNT_W-1:0] out_entry_count;

  cmd_word_t cmd_queue[$];
  result_t   expected_words[$];
  int        words_sent;
  int        mismatches;
  int        cycles;

  // predicted list contents
  logic [pal_pkg::CODE_W-1:0] list_codes[pal_pkg::ENTRIES];
  bit                         list_ann[pal_pkg::ENTRIES];
  int                         list_count;
  bit                         emptied_flag;

  pending_alarm_list u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_alarm_code_in   (in_alarm_code_in),
    .out_valid          (out_valid),
    .out_alarm_code_out (out_alarm_code_out),
    .out_alarm_found    (out_alarm_found),
    .out_list_emptied   (out_list_emptied),
    .out_entry_count    (out_entry_count)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // drop entry idx, pack later entries down, return its announced mark
  function automatic bit remove_entry(input int idx);
    bit was;
    int k;
    was = list_ann[idx];
    for (k = idx; k + 1 < list_count; k++) begin
      list_codes[k] = list_codes[k+1];
      list_ann[k]   = list_ann[k+1];
    end
    list_count--;
    list_codes[list_count] = '0;
    list_ann[list_count]   = 1'b0;
    return was;
  endfunction

  // apply one command to the predicted list and return the result word
  function automatic result_t apply_command(input logic [2:0] op,
                                            input logic [pal_pkg::CODE_W-1:0] code);
    result_t r;
    bit held;
    bit done;
    bit any_marked;
    int k;
    r = '0;
    held = 1'b0;
    done = 1'b0;
    any_marked = 1'b0;
    case (op)
      pal_pkg::OP_ADD: begin
        if (list_count < pal_pkg::ENTRIES) begin
          emptied_flag = 1'b0;
          for (k = 0; k < list_count; k++)
            if (list_codes[k] == code) held = 1'b1;
          if (!held) begin
            list_codes[list_count] = code;
            list_ann[list_count]   = 1'b0;
            list_count++;
          end
        end
      end
      pal_pkg::OP_DEL: begin
        k = 0;
        while (k < list_count && !done) begin
          if (list_codes[k] == code) begin
            if (remove_entry(k))
              for (int m = 0; m < pal_pkg::ENTRIES; m++) list_ann[m] = 1'b0;
            if (list_count == 0) emptied_flag = 1'b1;
            done = 1'b1;
          end else begin
            k++;
          end
        end
      end
      pal_pkg::OP_DGRP: begin
        k = 0;
        while (k < list_count) begin
          if (list_codes[k][pal_pkg::CODE_W-1:pal_pkg::GRP_LSB] ==
              code[pal_pkg::CODE_W-1:pal_pkg::GRP_LSB]) begin
            if (remove_entry(k)) any_marked = 1'b1;
            if (list_count == 0) emptied_flag = 1'b1;
          end else begin
            k++;
          end
        end
        if (any_marked)
          for (int m = 0; m < pal_pkg::ENTRIES; m++) list_ann[m] = 1'b0;
      end
      pal_pkg::OP_GET: begin
        k = 0;
        while (k < list_count && !done) begin
          if (!list_ann[k]) begin
            list_ann[k] = 1'b1;
            r.code  = list_codes[k];
            r.found = 1'b1;
            done = 1'b1;
          end else begin
            k++;
          end
        end
      end
      pal_pkg::OP_CLR: begin
        for (k = 0; k < pal_pkg::ENTRIES; k++) begin
          list_codes[k] = '0;
          list_ann[k]   = 1'b0;
        end
        list_count = 0;
      end
      pal_pkg::OP_POLL: begin
        r.emptied    = emptied_flag;
        emptied_flag = 1'b0;
      end
      default: ;
    endcase
    r.cnt = pal_pkg::OUT_CNT_W'(list_count);
    return r;
  endfunction

  task automatic push_cmd(input logic [2:0] op, input logic [pal_pkg::CODE_W-1:0] code);
    cmd_queue.push_back('{op: op, code: code});
  endtask

  // codes mostly from a small pool so duplicates, deletes and groups hit
  function automatic logic [pal_pkg::CODE_W-1:0] pick_code();
    logic [7:0] hi;
    logic [7:0] lo;
    if ($urandom_range(99) < 25) return pal_pkg::CODE_W'($urandom);
    case ($urandom_range(3))
      0: hi = 8'h00;
      1: hi = 8'hFF;
      2: hi = 8'h3C;
      default: hi = 8'hC3;
    endcase
    case ($urandom_range(4))
      0: lo = 8'h00;
      1: lo = 8'hFF;
      2: lo = 8'h5A;
      3: lo = 8'hA5;
      default: lo = 8'h01;
    endcase
    return {hi, lo};
  endfunction

  function automatic logic [2:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 36) return pal_pkg::OP_ADD;
    if (r < 56) return pal_pkg::OP_DEL;
    if (r < 66) return pal_pkg::OP_DGRP;
    if (r < 85) return pal_pkg::OP_GET;
    if (r < 88) return pal_pkg::OP_CLR;
    return pal_pkg::OP_POLL;
  endfunction

  // driver: present the next word, record the prediction when it is taken
  always @(posedge clk) begin : driver
    bit idle_now;
    cmd_word_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_words.push_back(apply_command(in_operation, in_alarm_code_in));
        words_sent++;
      end
      if (!start || !busy) begin
        // quiet stretch with no gaps in the middle of the run
        idle_now = (words_sent < 700 || words_sent >= 1100) && ($urandom_range(99) < 18);
        if (cmd_queue.size() > 0 && !idle_now) begin
          nxt = cmd_queue.pop_front();
          start            <= 1'b1;
          in_operation     <= nxt.op;
          in_alarm_code_in <= nxt.code;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word against the oldest prediction
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst_n && out_valid) begin
      got = {out_alarm_code_out, out_alarm_found, out_list_emptied, out_entry_count};
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: code %h found %b emptied %b count %0d",
                 $time, got.code, got.found, got.emptied, got.cnt);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected code %h found %b emptied %b count %0d",
                   $time, want.code, want.found, want.emptied, want.cnt);
          $display("%0t           actual   code %h found %b emptied %b count %0d",
                   $time, got.code, got.found, got.emptied, got.cnt);
          mismatches++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_operation     = pal_pkg::OP_ADD;
    in_alarm_code_in = '0;
    words_sent       = 0;
    mismatches       = 0;
    cycles           = 0;
    for (int k = 0; k < pal_pkg::ENTRIES; k++) begin
      list_codes[k] = '0;
      list_ann[k]   = 1'b0;
    end
    list_count   = 0;
    emptied_flag = 1'b0;

    // directed: empty list, duplicates, announce and delete, emptying
    push_cmd(pal_pkg::OP_POLL, 16'h0000);
    push_cmd(pal_pkg::OP_GET,  16'hFFFF);
    push_cmd(pal_pkg::OP_ADD,  16'h0000);
    push_cmd(pal_pkg::OP_ADD,  16'hFFFF);
    push_cmd(pal_pkg::OP_ADD,  16'hFFFF);
    push_cmd(pal_pkg::OP_GET,  16'h0000);
    push_cmd(pal_pkg::OP_DEL,  16'h0000);
    push_cmd(pal_pkg::OP_GET,  16'h0000);
    push_cmd(pal_pkg::OP_GET,  16'h0000);
    push_cmd(pal_pkg::OP_DEL,  16'h1234);
    push_cmd(pal_pkg::OP_DEL,  16'hFFFF);
    push_cmd(pal_pkg::OP_POLL, 16'hFFFF);
    // fill to capacity with adjacent group members at the head
    push_cmd(pal_pkg::OP_ADD,  16'h1201);
    push_cmd(pal_pkg::OP_ADD,  16'h1202);
    push_cmd(pal_pkg::OP_ADD,  16'h3401);
    push_cmd(pal_pkg::OP_ADD,  16'h1203);
    push_cmd(pal_pkg::OP_ADD,  16'h5601);
    push_cmd(pal_pkg::OP_ADD,  16'h1204);
    push_cmd(pal_pkg::OP_ADD,  16'h1205);
    push_cmd(pal_pkg::OP_ADD,  16'h7801);
    push_cmd(pal_pkg::OP_ADD,  16'h9999);
    push_cmd(pal_pkg::OP_GET,  16'h0000);
    push_cmd(pal_pkg::OP_DGRP, 16'h12AA);
    push_cmd(pal_pkg::OP_CLR,  16'h0000);
    push_cmd(OP_UNDEF_LO, 16'hFFFF);
    push_cmd(OP_UNDEF_HI, 16'h5555);

    // random commands
    for (int i = 0; i < RANDOM_WORDS; i++)
      push_cmd(pick_op(), pick_code());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() > 0 || start) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pending_alarm_list.sv
tb/pending_alarm_list_tb.sv
